[hdl/tlbpt_pkg.sv]
// shared types, constants and table builders for the tlb page table translator
package tlbpt_pkg;

  localparam int ADDR_W      = 16;
  localparam int PAGE_NUM_W  = 8;
  localparam int OFFSET_W    = 8;
  localparam int FRAME_NUM_W = 8;
  localparam int CFG_W       = 9;
  localparam int CNT_W       = 16;

  localparam int PAGES_DEF       = 256;
  localparam int TLB_ENTRIES_DEF = 16;
  localparam int FRAMES_DEF      = 256;

  localparam logic [CFG_W-1:0] FRAMES_RESET = 9'd256;
  localparam logic [CNT_W-1:0] CNT_MAX      = 16'hFFFF;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_LOOK,
    ST_WALK,
    ST_FIN
  } xlat_state_t;

  // update strobes from the sequencer to the tlb
  typedef struct packed {
    logic                   inval_en;
    logic [FRAME_NUM_W-1:0] inval_frame;
    logic                   write_en;
    logic [PAGE_NUM_W-1:0]  write_page;
    logic [FRAME_NUM_W-1:0] write_frame;
  } tlb_upd_t;

  // page number reduced modulo the page count, built by counting
  function automatic logic [255:0][PAGE_NUM_W-1:0] page_mod_table(input int unsigned pages);
    logic [255:0][PAGE_NUM_W-1:0] tbl;
    int unsigned                  r;
    r = 0;
    for (int i = 0; i < 256; i++) begin
      tbl[i] = r[PAGE_NUM_W-1:0];
      if (r + 1 == pages) begin
        r = 0;
      end else begin
        r = r + 1;
      end
    end
    return tbl;
  endfunction

endpackage

[hdl/tlb_page_table_translator_unit.sv]
// top level: address translator with tlb, page table and fifo frame replacement
//
// input channel: in_valid / in_ready carry one 16-bit logical address per
// transaction (page in bits 15-8, offset in bits 7-0). output channel:
// out_valid / out_ready carry the physical address, hit / fault / eviction
// flags and the saturating hit and fault totals.
// one address is translated at a time. a tlb hit passes through the accept,
// lookup and result load states; a miss adds a walk state before the result
// load, which uses the registered read of the page table ram and the frame
// owner ram, followed by the write back of both. the sequencer sets the rate.
// a new transaction is accepted while the previous result still sits in the
// output register; if the receiver stalls, the finished translation waits
// in the final state until the output register frees up.
// reset (rst, synchronous) clears page valid bits, the count of frames handed
// out, tlb valid bits and head, the frame pointer and both counters, and sets
// the frame count register to 256. the rams need no clearing pass.
// cfg_wr_en / cfg_wr_data write the frame count; write only while idle.
module tlb_page_table_translator_unit #(
  parameter int PAGES       = tlbpt_pkg::PAGES_DEF,
  parameter int TLB_ENTRIES = tlbpt_pkg::TLB_ENTRIES_DEF,
  parameter int FRAMES      = tlbpt_pkg::FRAMES_DEF
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             cfg_wr_en,
  input  logic [tlbpt_pkg::CFG_W-1:0]      cfg_wr_data,
  input  logic                             in_valid,
  output logic                             in_ready,
  input  logic [tlbpt_pkg::ADDR_W-1:0]     logical_address,
  output logic                             out_valid,
  input  logic                             out_ready,
  output logic [tlbpt_pkg::ADDR_W-1:0]     physical_address,
  output logic                             tlb_hit,
  output logic                             page_fault,
  output logic                             frame_evicted,
  output logic [tlbpt_pkg::CNT_W-1:0]      hit_total,
  output logic [tlbpt_pkg::CNT_W-1:0]      fault_total
);

  localparam int PAGE_W  = $clog2(PAGES);
  localparam int FRAME_W = (FRAMES > 1) ? $clog2(FRAMES) : 1;
  localparam logic [tlbpt_pkg::CFG_W-1:0] FRAMES_C = tlbpt_pkg::CFG_W'(FRAMES);
  localparam logic [255:0][tlbpt_pkg::PAGE_NUM_W-1:0] PAGE_MOD =
    tlbpt_pkg::page_mod_table(PAGES);

  tlbpt_pkg::xlat_state_t state, state_next;

  // transaction held for the duration of the translation
  logic [PAGE_W-1:0]               page_q;
  logic [tlbpt_pkg::OFFSET_W-1:0]  offset_q;

  // result being built
  logic [tlbpt_pkg::FRAME_NUM_W-1:0] frame_q;
  logic                              hit_q;
  logic                              fault_q;
  logic                              evict_q;

  logic [PAGES-1:0]                page_valid;
  logic [tlbpt_pkg::CFG_W-1:0]     frames_filled;
  logic [FRAME_W-1:0]              next_frame;
  logic [FRAME_W-1:0]              next_frame_next;
  logic [tlbpt_pkg::CFG_W-1:0]     frames_in_use;
  logic [tlbpt_pkg::CFG_W-1:0]     eff_frames;
  logic [tlbpt_pkg::CFG_W-1:0]     frame_inc;
  logic [tlbpt_pkg::CNT_W-1:0]     hit_counter;
  logic [tlbpt_pkg::CNT_W-1:0]     fault_counter;

  logic [FRAME_W-1:0]              pt_rdata;
  logic [PAGE_W-1:0]               own_rdata;

  logic                            lookup_hit;
  logic                            look_en;
  logic                            walk_en;
  logic                            walk_fault;
  logic                            walk_evict;
  logic                            out_load;
  logic [tlbpt_pkg::FRAME_NUM_W-1:0] miss_frame;

  logic                            tlb_lookup_hit;
  logic [tlbpt_pkg::FRAME_NUM_W-1:0] tlb_lookup_frame;
  tlbpt_pkg::tlb_upd_t             tlb_upd;

  // frame count register, 0 acts as 1 and anything above the frame count
  // saturates to it
  always_ff @(posedge clk) begin
    if (rst) begin
      frames_in_use <= tlbpt_pkg::FRAMES_RESET;
    end else if (cfg_wr_en) begin
      frames_in_use <= cfg_wr_data;
    end
  end

  always_comb begin
    if (frames_in_use == '0) begin
      eff_frames = tlbpt_pkg::CFG_W'(1);
    end else if (frames_in_use > FRAMES_C) begin
      eff_frames = FRAMES_C;
    end else begin
      eff_frames = frames_in_use;
    end
    frame_inc       = tlbpt_pkg::CFG_W'(next_frame) + tlbpt_pkg::CFG_W'(1);
    next_frame_next = (frame_inc >= eff_frames) ? '0 : frame_inc[FRAME_W-1:0];
  end

  // sequencer: next state
  always_comb begin
    state_next = state;
    case (state)
      tlbpt_pkg::ST_IDLE: begin
        if (in_valid) begin
          state_next = tlbpt_pkg::ST_LOOK;
        end
      end
      tlbpt_pkg::ST_LOOK: begin
        state_next = tlb_lookup_hit ? tlbpt_pkg::ST_FIN : tlbpt_pkg::ST_WALK;
      end
      tlbpt_pkg::ST_WALK: begin
        state_next = tlbpt_pkg::ST_FIN;
      end
      tlbpt_pkg::ST_FIN: begin
        if (!out_valid || out_ready) begin
          state_next = tlbpt_pkg::ST_IDLE;
        end
      end
      default: begin
        state_next = tlbpt_pkg::ST_IDLE;
      end
    endcase
  end

  // sequencer: strobes
  always_comb begin
    in_ready   = 1'b0;
    look_en    = 1'b0;
    walk_en    = 1'b0;
    out_load   = 1'b0;
    case (state)
      tlbpt_pkg::ST_IDLE: in_ready = 1'b1;
      tlbpt_pkg::ST_LOOK: look_en  = 1'b1;
      tlbpt_pkg::ST_WALK: walk_en  = 1'b1;
      tlbpt_pkg::ST_FIN:  out_load = !out_valid || out_ready;
      default: begin
        in_ready = 1'b0;
      end
    endcase
    lookup_hit = look_en && tlb_lookup_hit;
    walk_fault = walk_en && !page_valid[page_q];
    // frames are handed out in order from zero, so a frame below the fill
    // count is taken
    walk_evict = walk_fault && (tlbpt_pkg::CFG_W'(next_frame) < frames_filled);
    miss_frame = page_valid[page_q] ? tlbpt_pkg::FRAME_NUM_W'(pt_rdata)
                                    : tlbpt_pkg::FRAME_NUM_W'(next_frame);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= tlbpt_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      page_q   <= PAGE_MOD[logical_address[15:8]][PAGE_W-1:0];
      offset_q <= logical_address[7:0];
    end
  end

  // page table and frame owner rams; addresses stay put from lookup to walk,
  // and only one translation is in flight, so no forwarding is needed
  tlbpt_ram #(
    .WIDTH (FRAME_W),
    .DEPTH (PAGES)
  ) u_page_ram (
    .clk   (clk),
    .we    (walk_fault),
    .waddr (page_q),
    .wdata (next_frame),
    .raddr (page_q),
    .rdata (pt_rdata)
  );

  tlbpt_ram #(
    .WIDTH (PAGE_W),
    .DEPTH (FRAMES)
  ) u_owner_ram (
    .clk   (clk),
    .we    (walk_fault),
    .waddr (next_frame),
    .wdata (page_q),
    .raddr (next_frame),
    .rdata (own_rdata)
  );

  // tlb: every miss writes at the head, an eviction drops the stale entry
  always_comb begin
    tlb_upd.inval_en    = walk_evict;
    tlb_upd.inval_frame = tlbpt_pkg::FRAME_NUM_W'(next_frame);
    tlb_upd.write_en    = walk_en;
    tlb_upd.write_page  = tlbpt_pkg::PAGE_NUM_W'(page_q);
    tlb_upd.write_frame = miss_frame;
  end

  tlbpt_tlb #(
    .TLB_ENTRIES (TLB_ENTRIES)
  ) u_tlb (
    .clk         (clk),
    .rst         (rst),
    .lookup_page (tlbpt_pkg::PAGE_NUM_W'(page_q)),
    .upd         (tlb_upd),
    .hit         (tlb_lookup_hit),
    .hit_frame   (tlb_lookup_frame)
  );

  // mapping state: the owner ram names the single valid page of a taken frame
  always_ff @(posedge clk) begin
    if (rst) begin
      page_valid    <= '0;
      frames_filled <= '0;
      next_frame    <= '0;
      hit_counter   <= '0;
      fault_counter <= '0;
    end else begin
      if (lookup_hit && (hit_counter != tlbpt_pkg::CNT_MAX)) begin
        hit_counter <= hit_counter + tlbpt_pkg::CNT_W'(1);
      end
      if (walk_fault) begin
        if (fault_counter != tlbpt_pkg::CNT_MAX) begin
          fault_counter <= fault_counter + tlbpt_pkg::CNT_W'(1);
        end
        if (walk_evict) begin
          page_valid[own_rdata] <= 1'b0;
        end
        page_valid[page_q] <= 1'b1;
        if (tlbpt_pkg::CFG_W'(next_frame) >= frames_filled) begin
          frames_filled <= frame_inc;
        end
        next_frame <= next_frame_next;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (look_en) begin
      hit_q   <= tlb_lookup_hit;
      frame_q <= tlb_lookup_frame;
      fault_q <= 1'b0;
      evict_q <= 1'b0;
    end else if (walk_en) begin
      frame_q <= miss_frame;
      fault_q <= walk_fault;
      evict_q <= walk_evict;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      physical_address <= {frame_q, offset_q};
      tlb_hit          <= hit_q;
      page_fault       <= fault_q;
      frame_evicted    <= evict_q;
      hit_total        <= hit_counter;
      fault_total      <= fault_counter;
    end
  end

  // a result is either a tlb hit or a walk, never both a hit and a fault
  a_hit_not_fault: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> !(tlb_hit && page_fault))
    else $error("result flags both tlb hit and page fault");

  // eviction only comes with a fault
  a_evict_needs_fault: assert property (@(posedge clk) disable iff (rst)
    (out_valid && frame_evicted) |-> page_fault)
    else $error("frame eviction without page fault");

  // the frame pointer only moves on a fault
  a_pointer_moves_on_fault: assert property (@(posedge clk) disable iff (rst)
    !walk_fault |=> $stable(next_frame))
    else $error("frame pointer moved without a fault");

  // the counters never go backwards
  a_counters_monotone: assert property (@(posedge clk) disable iff (rst)
    1'b1 |=> (hit_counter >= $past(hit_counter)) &&
             (fault_counter >= $past(fault_counter)))
    else $error("hit or fault counter decreased");

endmodule

[hdl/tlbpt_ram.sv]
// generic single write port ram with registered read
module tlbpt_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  logic                                  clk,
  input  logic                                  we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                      wdata,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                      rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

[hdl/tlbpt_tlb.sv]
// fifo-replaced tlb with parallel lookup and first-match invalidation
module tlbpt_tlb #(
  parameter int TLB_ENTRIES = tlbpt_pkg::TLB_ENTRIES_DEF
) (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic [tlbpt_pkg::PAGE_NUM_W-1:0]     lookup_page,
  input  tlbpt_pkg::tlb_upd_t                  upd,
  output logic                                 hit,
  output logic [tlbpt_pkg::FRAME_NUM_W-1:0]    hit_frame
);

  localparam int TLB_W = (TLB_ENTRIES > 1) ? $clog2(TLB_ENTRIES) : 1;
  localparam logic [TLB_W-1:0] HEAD_LAST = TLB_W'(TLB_ENTRIES - 1);

  logic [tlbpt_pkg::PAGE_NUM_W-1:0]  tlb_page  [TLB_ENTRIES];
  logic [tlbpt_pkg::FRAME_NUM_W-1:0] tlb_frame [TLB_ENTRIES];
  logic [TLB_ENTRIES-1:0]            entry_valid;
  logic [TLB_ENTRIES-1:0]            entry_valid_next;
  logic [TLB_ENTRIES-1:0]            inval_sel;
  logic [TLB_W-1:0]                  head;

  // lowest matching entry wins, for lookup and for invalidation alike
  always_comb begin
    hit       = 1'b0;
    hit_frame = '0;
    inval_sel = '0;
    for (int i = TLB_ENTRIES - 1; i >= 0; i--) begin
      if (entry_valid[i] && (tlb_page[i] == lookup_page)) begin
        hit       = 1'b1;
        hit_frame = tlb_frame[i];
      end
      if (entry_valid[i] && (tlb_frame[i] == upd.inval_frame)) begin
        inval_sel    = '0;
        inval_sel[i] = 1'b1;
      end
    end
  end

  // invalidation first, then the new entry at the head
  always_comb begin
    entry_valid_next = entry_valid;
    if (upd.inval_en) begin
      entry_valid_next = entry_valid_next & ~inval_sel;
    end
    if (upd.write_en) begin
      entry_valid_next[head] = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      entry_valid <= '0;
      head        <= '0;
    end else begin
      entry_valid <= entry_valid_next;
      if (upd.write_en) begin
        head <= (head == HEAD_LAST) ? '0 : head + TLB_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (upd.write_en) begin
      tlb_page[head]  <= upd.write_page;
      tlb_frame[head] <= upd.write_frame;
    end
  end

endmodule

[tb/tb_top.sv]
// testbench for the tlb page table translator: driven queue, self-predicting monitor
`timescale 1ns / 100ps

module tb_top;
  import tlbpt_pkg::*;

  localparam int          CLK_HALF     = 2;
  localparam int unsigned CYCLE_LIMIT  = 4_000_000;
  localparam int          DRAIN_CYCLES = 10;

  // one translation as seen on the output channel
  typedef struct packed {
    logic [ADDR_W-1:0] physical_address;
    logic              tlb_hit;
    logic              page_fault;
    logic              frame_evicted;
    logic [CNT_W-1:0]  hit_total;
    logic [CNT_W-1:0]  fault_total;
  } xlat_result_t;

  // every block input has a known value from time zero
  logic                 clk             = 1'b0;
  logic                 rst             = 1'b1;
  logic                 cfg_wr_en       = 1'b0;
  logic [CFG_W-1:0]     cfg_wr_data     = '0;
  logic                 in_valid        = 1'b0;
  logic                 in_ready;
  logic [ADDR_W-1:0]    logical_address = '0;
  logic                 out_valid;
  logic                 out_ready       = 1'b0;
  logic [ADDR_W-1:0]    physical_address;
  logic                 tlb_hit;
  logic                 page_fault;
  logic                 frame_evicted;
  logic [CNT_W-1:0]     hit_total;
  logic [CNT_W-1:0]     fault_total;

  // addresses waiting to be offered, and translations waiting to come out
  logic [ADDR_W-1:0]    pending_addresses[$];
  xlat_result_t         expected_translations[$];

  // idling controls, changed by the sequence on falling edges only
  int unsigned          send_idle_pct  = 0;
  int unsigned          recv_stall_pct = 0;
  int unsigned          hold_request   = 0;
  int unsigned          hold_left      = 0;

  int unsigned          mismatches  = 0;
  int unsigned          cycle_count = 0;

  // shadow copy of the translator state
  bit                   pt_valid   [PAGES_DEF];
  logic [FRAME_NUM_W-1:0] pt_frame [PAGES_DEF];
  bit                   frame_used [FRAMES_DEF];
  logic [PAGE_NUM_W-1:0]  tlb_pg   [TLB_ENTRIES_DEF];
  logic [FRAME_NUM_W-1:0] tlb_fr   [TLB_ENTRIES_DEF];
  bit                   tlb_vld    [TLB_ENTRIES_DEF];
  logic [3:0]           tlb_wr_ptr  = '0;
  logic [FRAME_NUM_W-1:0] frame_ptr = '0;
  logic [CNT_W-1:0]     hit_count   = '0;
  logic [CNT_W-1:0]     fault_count = '0;
  logic [CFG_W-1:0]     frame_limit = FRAMES_RESET;

  tlb_page_table_translator_unit DUT (
    .clk              (clk),
    .rst              (rst),
    .cfg_wr_en        (cfg_wr_en),
    .cfg_wr_data      (cfg_wr_data),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .logical_address  (logical_address),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .physical_address (physical_address),
    .tlb_hit          (tlb_hit),
    .page_fault       (page_fault),
    .frame_evicted    (frame_evicted),
    .hit_total        (hit_total),
    .fault_total      (fault_total)
  );

  always #(CLK_HALF) clk = ~clk;

  // translate one address against the shadow state and advance that state
  function automatic xlat_result_t translate_address(input logic [ADDR_W-1:0] la);
    xlat_result_t           r;
    logic [PAGE_NUM_W-1:0]  pg;
    logic [FRAME_NUM_W-1:0] fr;
    int unsigned            nf;
    int                     i;
    bit                     found;
    bit                     done;
    r     = '0;
    pg    = la[ADDR_W-1:OFFSET_W];
    fr    = '0;
    found = 1'b0;
    // parallel tlb compare, lowest valid index wins
    for (i = 0; i < TLB_ENTRIES_DEF; i++) begin
      if (!found && tlb_vld[i] && tlb_pg[i] == pg) begin
        found = 1'b1;
        fr    = tlb_fr[i];
      end
    end
    if (found) begin
      if (hit_count != CNT_MAX) hit_count = hit_count + 1'b1;
    end else begin
      if (pt_valid[pg]) begin
        fr = pt_frame[pg];
      end else begin
        // zero frames acts as one, anything above the frame count is clamped
        if (frame_limit == 0) nf = 1;
        else if (frame_limit > FRAMES_DEF) nf = FRAMES_DEF;
        else nf = frame_limit;
        r.page_fault = 1'b1;
        if (fault_count != CNT_MAX) fault_count = fault_count + 1'b1;
        // pointer may sit beyond a lowered count; that frame is still taken
        fr = frame_ptr;
        if (frame_used[fr]) begin
          r.frame_evicted = 1'b1;
          done = 1'b0;
          for (i = 0; i < PAGES_DEF; i++) begin
            if (!done && pt_valid[i] && pt_frame[i] == fr) begin
              pt_valid[i] = 1'b0;
              done        = 1'b1;
            end
          end
          done = 1'b0;
          for (i = 0; i < TLB_ENTRIES_DEF; i++) begin
            if (!done && tlb_vld[i] && tlb_fr[i] == fr) begin
              tlb_vld[i] = 1'b0;
              done       = 1'b1;
            end
          end
        end
        pt_frame[pg]   = fr;
        pt_valid[pg]   = 1'b1;
        frame_used[fr] = 1'b1;
        frame_ptr      = (int'(fr) + 1 >= nf) ? '0 : fr + 1'b1;
      end
      // every miss fills the tlb slot at the fifo head
      tlb_pg[tlb_wr_ptr]  = pg;
      tlb_fr[tlb_wr_ptr]  = fr;
      tlb_vld[tlb_wr_ptr] = 1'b1;
      tlb_wr_ptr          = tlb_wr_ptr + 1'b1;
    end
    r.physical_address = {fr, la[OFFSET_W-1:0]};
    r.tlb_hit          = found;
    r.hit_total        = hit_count;
    r.fault_total      = fault_count;
    return r;
  endfunction

  // sender: prediction is taken at the edge where the transaction is accepted
  always @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && in_ready) begin
        expected_translations.push_back(translate_address(logical_address));
      end
      if (!in_valid || in_ready) begin
        if (pending_addresses.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
          in_valid        <= 1'b1;
          logical_address <= pending_addresses.pop_front();
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // receiver: random stalls, plus a long counted hold-off on request
  always @(posedge clk) begin
    if (rst) begin
      out_ready <= 1'b0;
    end else if (hold_left != 0) begin
      out_ready <= 1'b0;
      hold_left <= hold_left - 1;
    end else if (hold_request != 0) begin
      out_ready    <= 1'b0;
      hold_left    <= hold_request;
      hold_request = 0;
    end else begin
      out_ready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  // monitor: each result against the oldest outstanding translation
  always @(posedge clk) begin
    xlat_result_t got;
    xlat_result_t want;
    if (!rst && out_valid && out_ready) begin
      got = '{physical_address, tlb_hit, page_fault, frame_evicted, hit_total, fault_total};
      if (expected_translations.size() == 0) begin
        if (mismatches < 10) begin
          $display("unexpected translation result at cycle %0d: pa=%h", cycle_count,
                   physical_address);
        end
        mismatches++;
      end else begin
        want = expected_translations.pop_front();
        if (got !== want) begin
          if (mismatches < 10) begin
            $display("mismatch at cycle %0d: expected pa=%h hit=%b fault=%b evict=%b",
                     cycle_count, want.physical_address, want.tlb_hit, want.page_fault,
                     want.frame_evicted);
            $display("  expected hits=%0d faults=%0d; got pa=%h hit=%b fault=%b evict=%b",
                     want.hit_total, want.fault_total, got.physical_address, got.tlb_hit,
                     got.page_fault, got.frame_evicted);
            $display("  got hits=%0d faults=%0d", got.hit_total, got.fault_total);
          end
          mismatches++;
        end
      end
    end
  end

  // watchdog against a hung handshake
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("CHECKS FAILED");
      $finish;
    end
  end

  // frame count write, only ever issued while the translator is idle
  task automatic set_frames(input logic [CFG_W-1:0] value);
    @(posedge clk);
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= value;
    @(posedge clk);
    cfg_wr_en   <= 1'b0;
    frame_limit = value;
    @(negedge clk);
  endtask

  // wait for every queued address to come back, then let the pipeline settle
  task automatic wait_until_idle();
    do @(negedge clk);
    while (pending_addresses.size() != 0 || in_valid || expected_translations.size() != 0);
    repeat (DRAIN_CYCLES) @(negedge clk);
  endtask

  // mostly a shifting working set of pages, so the tlb and page table both
  // get hits and small frame counts evict often; some fully random addresses
  task automatic queue_random_addresses(input int unsigned count);
    int unsigned n;
    int unsigned ws;
    int unsigned base;
    ws   = 2;
    base = 0;
    for (n = 0; n < count; n++) begin
      if (n % 50 == 0) begin
        case ($urandom_range(3))
          0: ws = 2;
          1: ws = 6;
          2: ws = 18;
          default: ws = 40;
        endcase
        base = $urandom_range(255);
      end
      if ($urandom_range(99) < 10) begin
        pending_addresses.push_back(ADDR_W'($urandom));
      end else begin
        pending_addresses.push_back({PAGE_NUM_W'((base + $urandom_range(ws - 1)) % 256),
                                     OFFSET_W'($urandom)});
      end
    end
  endtask

  initial begin
    int unsigned phase;
    int unsigned n;
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // directed: offset extremes, tlb hits, page table hit once the tlb wraps
    set_frames(FRAMES_RESET);
    pending_addresses.push_back(16'h0000);
    pending_addresses.push_back(16'h00FF);
    pending_addresses.push_back(16'hFFFF);
    pending_addresses.push_back(16'hFF00);
    pending_addresses.push_back(16'hA55A);
    pending_addresses.push_back(16'h5AA5);
    for (n = 1; n <= 13; n++) begin
      pending_addresses.push_back({PAGE_NUM_W'(n), ~OFFSET_W'(n)});
    end
    pending_addresses.push_back(16'h0080);
    pending_addresses.push_back(16'h0081);
    wait_until_idle();

    // count lowered below the frame pointer: that frame is used, then wrap
    // to frame zero, which evicts page zero
    set_frames(9'd5);
    pending_addresses.push_back(16'h3033);
    pending_addresses.push_back(16'h3144);
    pending_addresses.push_back(16'h0012);
    wait_until_idle();

    // zero frames behaves as a single frame
    set_frames(9'd0);
    pending_addresses.push_back(16'h4000);
    pending_addresses.push_back(16'h41FF);
    wait_until_idle();

    // above the frame count clamps to the full set
    set_frames(9'd511);
    pending_addresses.push_back(16'h5055);
    wait_until_idle();

    // random phases over the idling modes and a spread of frame counts
    for (phase = 0; phase < 9; phase++) begin
      case (phase % 4)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 81; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 81; end
        default: begin send_idle_pct = 37; recv_stall_pct = 37; end
      endcase
      case (phase)
        0: set_frames(9'd256);
        1: set_frames(9'd2);
        2: set_frames(9'd17);
        3: set_frames(9'd1);
        4: set_frames(9'd3);
        5: set_frames(9'd16);
        6: set_frames(9'd511);
        7: set_frames(9'd0);
        default: set_frames(CFG_W'($urandom_range(511)));
      endcase
      // back-pressure: the sender keeps offering while the output is held
      if (phase == 4) hold_request = 400;
      queue_random_addresses(150);
      wait_until_idle();
    end

    if (mismatches == 0 && expected_translations.size() == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
